// ===== rtl/lirr_pkg.sv =====
// Shared constants, register indexes and control structs of the linear-interpolation resampler.
package lirr_pkg;

   localparam int DEFAULT_MAX_FACTOR  = 16;
   localparam int DEFAULT_SAMPLE_BITS = 16;

   localparam int FACTOR_WIDTH   = 5;
   localparam int PHASE_BITS     = 4;
   localparam int PHASE_LIMIT    = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [FACTOR_WIDTH-1:0] UP_FACTOR_RESET   = 5'd2;
   localparam logic [FACTOR_WIDTH-1:0] DOWN_FACTOR_RESET = 5'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UP_FACTOR   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOWN_FACTOR = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic setup;
      logic point_step;
      logic flush;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                    first_pending;
      logic                    kept;
      logic                    held_valid;
      logic                    push_ok;
      logic [FACTOR_WIDTH-1:0] m_eff;
   } status_type;

endpackage

// ===== rtl/lirr_req_if.sv =====
// Input sample channel.
interface lirr_req_if #(
   parameter int SAMPLE_BITS = lirr_pkg::DEFAULT_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          stream_end;

   modport source (output valid, output sample_in, output stream_end, input ready);
   modport sink   (input valid, input sample_in, input stream_end, output ready);
endinterface

// ===== rtl/lirr_rsp_if.sv =====
// Result sample channel.
interface lirr_rsp_if #(
   parameter int SAMPLE_BITS = lirr_pkg::DEFAULT_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          run_last;

   modport source (output valid, output sample_out, output run_last, input ready);
   modport sink   (input valid, input sample_out, input run_last, output ready);
endinterface

// ===== rtl/lirr_csr_if.sv =====
// Configuration register write channel.
interface lirr_csr_if ();
   logic                                  valid;
   logic                                  ready;
   logic [lirr_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [lirr_pkg::FACTOR_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lirr_ctrl.sv =====
// Sequencer of the resampler: divide, set up, walk the points, flush the held item.
module lirr_ctrl #(
   parameter int SAMPLE_BITS = lirr_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lirr_pkg::status_type status,
   output lirr_pkg::cmd_type    cmd
);
   localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS);
   localparam int W            = lirr_pkg::FACTOR_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETUP,
      ST_POINT,
      ST_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic [W-1:0]            pts_ff, pts_in;
   logic                    stall;

   assign req_ready = (state_ff == ST_IDLE);
   assign stall     = status.kept && status.held_valid && !status.push_ok;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      pts_in     = pts_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               div_cnt_in = '0;
               state_in   = status.first_pending ? ST_SETUP : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(SAMPLE_BITS - 1)) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            pts_in    = status.first_pending ? W'(1) : status.m_eff;
            state_in  = ST_POINT;
         end
         ST_POINT: begin
            if (!stall) begin
               cmd.point_step = 1'b1;
               pts_in         = pts_ff - 1'b1;
               if (pts_ff == W'(1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.held_valid || status.push_ok) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
         pts_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         pts_ff     <= pts_in;
      end
   end

   a_point_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POINT |-> pts_ff != '0)
      else $error("point walk entered with no points left");

   a_first_skips_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !status.first_pending)
      else $error("divider started on the first sample of a stream");

   a_flush_goes_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> state_ff == ST_IDLE)
      else $error("flush did not end the item");

endmodule

// ===== rtl/lirr_datapath.sv =====
// Datapath: config registers, serial divider, incremental interpolator, hold and output registers.
module lirr_datapath #(
   parameter int MAX_FACTOR  = lirr_pkg::DEFAULT_MAX_FACTOR,
   parameter int SAMPLE_BITS = lirr_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   input  logic                                req_stream_end,
   input  logic                                csr_write,
   input  logic [lirr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lirr_pkg::FACTOR_WIDTH-1:0]   csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   output logic                                rsp_run_last,
   input  lirr_pkg::cmd_type                   cmd,
   output lirr_pkg::status_type                status
);
   localparam int SB = SAMPLE_BITS;
   localparam int W  = lirr_pkg::FACTOR_WIDTH;
   localparam int PB = lirr_pkg::PHASE_BITS;

   function automatic logic [W-1:0] clamp_factor(input logic [W-1:0] v, input int hi);
      logic [W-1:0] r;
      r = v;
      if (v == '0) begin
         r = W'(1);
      end else if (int'(v) > hi) begin
         r = W'(hi);
      end
      return r;
   endfunction

   // configuration
   logic [W-1:0] up_ff, down_ff;
   logic [W-1:0] m_eff, l_eff;

   // stream state
   logic signed [SB-1:0] prev_ff, cur_ff;
   logic                 end_ff;
   logic                 first_ff;
   logic [PB-1:0]        phase_ff;

   // divider: dividend shifts out the top while quotient bits enter the bottom
   logic [SB-1:0] div_ff, div_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic          neg_ff;

   // interpolator: current point is acc_q + acc_r / M
   logic signed [SB:0]   dq_ff, dq_in;
   logic [W-1:0]         dr_ff, dr_in;
   logic signed [SB+1:0] acc_q_ff, acc_q_in;
   logic [W-1:0]         acc_r_ff, acc_r_in;

   // one kept point held back until it is known whether it closes the run
   logic                 held_valid_ff;
   logic signed [SB-1:0] held_ff;

   logic                 rsp_valid_ff;
   logic signed [SB-1:0] rsp_sample_ff;
   logic                 rsp_last_ff;

   logic signed [SB:0]   delta;
   logic [SB:0]          delta_mag;
   logic [W:0]           trial;
   logic                 trial_ge;
   logic [SB:0]          q_ext;
   logic [W:0]           r_sum;
   logic                 wrap;
   logic [W-1:0]         r_next;
   logic signed [SB+1:0] q_next;
   logic [W:0]           two_r;
   logic                 round_up;
   logic signed [SB+1:0] point_full;
   logic signed [SB-1:0] point_val;
   logic [PB:0]          phase_inc;
   logic [PB-1:0]        phase_next;
   logic                 kept;
   logic                 push_ok;
   logic                 push;

   assign m_eff   = clamp_factor(up_ff, MAX_FACTOR);
   assign l_eff   = clamp_factor(down_ff, lirr_pkg::PHASE_LIMIT);
   assign kept    = (phase_ff == '0);
   assign push_ok = !rsp_valid_ff || rsp_ready;
   // the held point moves to the output register
   assign push    = held_valid_ff && ((cmd.point_step && kept) || cmd.flush);

   assign status.first_pending = first_ff;
   assign status.kept          = kept;
   assign status.held_valid    = held_valid_ff;
   assign status.push_ok       = push_ok;
   assign status.m_eff         = m_eff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_run_last   = rsp_last_ff;

   always_comb begin
      delta     = (SB+1)'(req_sample_in) - (SB+1)'(prev_ff);
      delta_mag = delta[SB] ? -delta : delta;
   end

   always_comb begin
      trial    = {rem_ff, div_ff[SB-1]};
      trial_ge = (trial >= {1'b0, m_eff});
      rem_in   = trial_ge ? W'(trial - {1'b0, m_eff}) : trial[W-1:0];
      div_in   = {div_ff[SB-2:0], trial_ge};
   end

   // floor division of the step between samples: delta = dq*M + dr, 0 <= dr < M
   always_comb begin
      q_ext = {1'b0, div_ff};
      if (first_ff) begin
         dq_in    = '0;
         dr_in    = '0;
         acc_q_in = (SB+2)'(cur_ff);
      end else begin
         if (neg_ff && (rem_ff != '0)) begin
            dq_in = -(q_ext + 1'b1);
            dr_in = m_eff - rem_ff;
         end else if (neg_ff) begin
            dq_in = -q_ext;
            dr_in = '0;
         end else begin
            dq_in = q_ext;
            dr_in = rem_ff;
         end
         acc_q_in = (SB+2)'(prev_ff);
      end
      acc_r_in = '0;
   end

   // next point and its rounding, ties away from zero
   always_comb begin
      r_sum      = {1'b0, acc_r_ff} + {1'b0, dr_ff};
      wrap       = (r_sum >= {1'b0, m_eff});
      r_next     = wrap ? W'(r_sum - {1'b0, m_eff}) : r_sum[W-1:0];
      q_next     = acc_q_ff + (SB+2)'(dq_ff) + {{(SB+1){1'b0}}, wrap};
      two_r      = {r_next, 1'b0};
      round_up   = q_next[SB+1] ? (two_r > {1'b0, m_eff}) : (two_r >= {1'b0, m_eff});
      point_full = q_next + {{(SB+1){1'b0}}, round_up};
      point_val  = point_full[SB-1:0];
   end

   always_comb begin
      phase_inc  = {1'b0, phase_ff} + 1'b1;
      phase_next = (phase_inc >= (PB+1)'(l_eff)) ? '0 : phase_inc[PB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff    <= lirr_pkg::UP_FACTOR_RESET;
         down_ff  <= lirr_pkg::DOWN_FACTOR_RESET;
         prev_ff  <= '0;
         first_ff <= 1'b1;
         phase_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lirr_pkg::CSR_UP_FACTOR:   up_ff   <= csr_data;
               lirr_pkg::CSR_DOWN_FACTOR: down_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.point_step) begin
            phase_ff <= phase_next;
         end
         if (cmd.flush) begin
            if (end_ff) begin
               prev_ff  <= '0;
               first_ff <= 1'b1;
               phase_ff <= '0;
            end else begin
               prev_ff  <= cur_ff;
               first_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff <= req_sample_in;
         end_ff <= req_stream_end;
         div_ff <= delta_mag[SB-1:0];
         rem_ff <= '0;
         neg_ff <= delta[SB];
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
      if (cmd.setup) begin
         dq_ff    <= dq_in;
         dr_ff    <= dr_in;
         acc_q_ff <= acc_q_in;
         acc_r_ff <= acc_r_in;
      end else if (cmd.point_step) begin
         acc_q_ff <= q_next;
         acc_r_ff <= r_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.point_step && kept) begin
            held_valid_ff <= 1'b1;
         end else if (cmd.flush && held_valid_ff) begin
            held_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.point_step && kept) begin
         held_ff <= point_val;
         if (held_valid_ff) begin
            rsp_sample_ff <= held_ff;
            rsp_last_ff   <= 1'b0;
         end
      end else if (cmd.flush && held_valid_ff) begin
         rsp_sample_ff <= held_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   a_push_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.point_step && kept && held_valid_ff) || (cmd.flush && held_valid_ff) |-> push_ok)
      else $error("item pushed over an output item not yet taken");

   a_idle_has_no_held: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !held_valid_ff)
      else $error("held point left over from the previous item");

   a_divider_remainder: assert property (@(posedge clock) disable iff (reset)
      cmd.setup && !first_ff |-> rem_ff < m_eff)
      else $error("divider remainder not below the factor");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.point_step |=> (phase_ff == '0) || ((PB+1)'(phase_ff) < (PB+1)'(l_eff)))
      else $error("keep phase escaped its period");

endmodule

// ===== rtl/linear_interp_rational_resampler.sv =====
// Top level of the linear-interpolation rational resampler.
//
// Channels: req carries one input item (sample_in, stream_end); rsp carries
// result items (sample_out, run_last); csr writes up_factor (index 0) and
// down_factor (index 1) and is always ready. Write csr only while idle.
// Each input sample walks M = up_factor interpolated points between the
// held sample and itself (only the sample itself for the first of a
// stream); every down_factor-th point of the running index is sent, and
// the last one sent for an input carries run_last.
// Per item the controller divides (not for a stream's first sample),
// sets up, walks the points and flushes the held point. The divider
// makes one quotient bit per cycle to split the sample step by M; then
// one point a cycle unless a stall on rsp holds the walk. A new item is
// taken once the last kept point is in the output register. A stream's
// first sample goes through setup, point walk and flush only.
// A stall on rsp holds the walk when a second kept point meets a full
// output register. Reset empties the block, sets up_factor 2 and
// down_factor 3, and awaits a first sample.
module linear_interp_rational_resampler #(
   parameter int MAX_FACTOR  = lirr_pkg::DEFAULT_MAX_FACTOR,
   parameter int SAMPLE_BITS = lirr_pkg::DEFAULT_SAMPLE_BITS
) (
   input logic         clock,
   input logic         reset,
   lirr_req_if.sink    req,
   lirr_rsp_if.source  rsp,
   lirr_csr_if.sink    csr
);
   lirr_pkg::cmd_type    cmd;
   lirr_pkg::status_type status;
   logic                 req_ready;

   assign req.ready = req_ready;
   assign csr.ready = 1'b1;

   lirr_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lirr_datapath #(
      .MAX_FACTOR  (MAX_FACTOR),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_sample_in  (req.sample_in),
      .req_stream_end (req.stream_end),
      .csr_write      (csr.valid),
      .csr_index      (csr.index),
      .csr_data       (csr.data),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_sample_out (rsp.sample_out),
      .rsp_run_last   (rsp.run_last),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== tb/sv/linear_interp_rational_resampler_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the linear-interpolation rational resampler.
module linear_interp_rational_resampler_test;

   localparam int SAMPLE_BITS  = lirr_pkg::DEFAULT_SAMPLE_BITS;
   localparam int MAX_FACTOR   = lirr_pkg::DEFAULT_MAX_FACTOR;
   localparam int FW           = lirr_pkg::FACTOR_WIDTH;
   localparam int DRAIN_CYCLES = 2 * (SAMPLE_BITS + MAX_FACTOR + 3);
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 165;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          run_last;
   } resampled_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lirr_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   lirr_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   lirr_csr_if csr_bus ();

   linear_interp_rational_resampler #(
      .MAX_FACTOR (MAX_FACTOR),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state and register copies
   logic [FW-1:0]                       up_reg         = lirr_pkg::UP_FACTOR_RESET;
   logic [FW-1:0]                       down_reg       = lirr_pkg::DOWN_FACTOR_RESET;
   logic signed [SAMPLE_BITS-1:0]       hist_sample    = '0;
   logic [lirr_pkg::PHASE_BITS-1:0]     phase_count    = '0;
   logic                                awaiting_first = 1'b1;

   resampled_point_type pending_points[$];

   bit idle_enable   = 1'b1;
   int hold_request  = 0;
   int error_count   = 0;
   int results_seen  = 0;
   int items_sent    = 0;
   int writes_done   = 0;
   int cycle_count   = 0;

   function automatic int clamp_factor(input logic [FW-1:0] v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   // true when the current point index is kept; advances the index
   function automatic bit take_point(input int lim);
      bit kept;
      kept = (phase_count == 0);
      if (int'(phase_count) + 1 >= lim) phase_count = '0;
      else phase_count = phase_count + 1'b1;
      return kept;
   endfunction

   // ((M-m)*prev + m*cur) / M, nearest, ties away from zero
   function automatic logic signed [SAMPLE_BITS-1:0] interp_point(
      input logic signed [SAMPLE_BITS-1:0] prev,
      input logic signed [SAMPLE_BITS-1:0] cur,
      input int m,
      input int m_fac);
      longint s;
      longint mag;
      longint q;
      s   = longint'(m_fac - m) * longint'(prev) + longint'(m) * longint'(cur);
      mag = (s < 0) ? -s : s;
      q   = (2 * mag + m_fac) / (2 * m_fac);
      return SAMPLE_BITS'((s < 0) ? -q : q);
   endfunction

   function automatic void predict_resample(input logic signed [SAMPLE_BITS-1:0] value,
                                            input logic last_flag);
      resampled_point_type step_points[$];
      int m_fac;
      int lim;
      m_fac = clamp_factor(up_reg, MAX_FACTOR);
      lim   = clamp_factor(down_reg, lirr_pkg::PHASE_LIMIT);
      if (awaiting_first) begin
         if (take_point(lim)) step_points.push_back('{value, 1'b0});
         awaiting_first = 1'b0;
      end else begin
         for (int m = 1; m < m_fac; m++) begin
            if (take_point(lim))
               step_points.push_back('{interp_point(hist_sample, value, m, m_fac), 1'b0});
         end
         if (take_point(lim)) step_points.push_back('{value, 1'b0});
      end
      hist_sample = value;
      if (step_points.size() > 0) step_points[step_points.size()-1].run_last = 1'b1;
      foreach (step_points[i]) pending_points.push_back(step_points[i]);
      if (last_flag) begin
         hist_sample    = '0;
         phase_count    = '0;
         awaiting_first = 1'b1;
      end
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last_flag);
      int gap;
      gap = idle_enable ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.sample_in  <= value;
      req_bus.stream_end <= last_flag;
      do @(posedge clock); while (!req_bus.ready);
      predict_resample(value, last_flag);
      items_sent++;
   endtask

   // all results in, plus time for an item that keeps no point
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lirr_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [FW-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == lirr_pkg::CSR_UP_FACTOR) up_reg = value;
      else down_reg = value;
      writes_done++;
      @(posedge clock);
   endtask

   task automatic set_factors(input logic [FW-1:0] up_val,
                              input logic [FW-1:0] down_val);
      wait_idle();
      write_reg(lirr_pkg::CSR_UP_FACTOR, up_val);
      write_reg(lirr_pkg::CSR_DOWN_FACTOR, down_val);
   endtask

   function automatic logic [FW-1:0] pick_factor();
      case ($urandom_range(0, 7))
         0: return FW'(1);
         1: return FW'(16);
         2: return FW'(0);
         3: return FW'($urandom_range(17, 31));
         default: return FW'($urandom_range(2, 8));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] next_sample(
      input logic signed [SAMPLE_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2, 3: return prev + SAMPLE_BITS'($urandom_range(0, 127) - 64);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      // M=2, L=3 straight out of reset
      send_sample('0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
   endtask

   task automatic test_rounding_ties();
      set_factors(5'd2, 5'd1);
      send_sample('0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample('0, 1'b1);
   endtask

   task automatic test_factor_extremes();
      set_factors(5'd16, 5'd1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(-16'sd1, 1'b1);
      set_factors(5'd1, 5'd1);
      send_sample(16'sd123, 1'b0);
      send_sample(-16'sd5, 1'b1);
      // zero factors act as one
      set_factors(5'd0, 5'd0);
      send_sample(16'sd77, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      // oversize factors clamp to sixteen
      set_factors(5'd31, 5'd17);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(16'sd1000, 1'b1);
   endtask

   task automatic test_phase_carry();
      // L=16 leaves items with no kept point and a high phase
      set_factors(5'd4, 5'd16);
      send_sample(16'sd4000, 1'b0);
      send_sample(-16'sd4000, 1'b0);
      send_sample(16'sd12345, 1'b0);
      // shrink L below the carried phase mid-stream
      wait_idle();
      write_reg(lirr_pkg::CSR_DOWN_FACTOR, 5'd2);
      send_sample(-16'sd321, 1'b0);
      send_sample(16'sd999, 1'b1);
   endtask

   task automatic test_output_stall();
      logic signed [SAMPLE_BITS-1:0] value;
      set_factors(5'd16, 5'd1);
      idle_enable  = 1'b0;
      hold_request = HOLD_CYCLES;
      value        = '0;
      for (int i = 0; i < 8; i++) begin
         value = next_sample(value);
         send_sample(value, 1'b0);
      end
      // sender pause until every result is back
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         value = next_sample(value);
         send_sample(value, i == 3);
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_random_streams(input int total);
      int sent;
      int phase_sent;
      int run_len;
      logic last_flag;
      logic signed [SAMPLE_BITS-1:0] value;
      sent  = 0;
      value = '0;
      while (sent < total) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_reg(lirr_pkg::CSR_DOWN_FACTOR, pick_factor());
         end else begin
            set_factors(pick_factor(), pick_factor());
         end
         idle_enable = ($urandom_range(0, 3) != 0);
         phase_sent  = 0;
         while (phase_sent < 25 && sent < total) begin
            run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++) begin
               // mostly whole streams; a few left open or cut short
               if (i == run_len - 1) last_flag = ($urandom_range(0, 5) != 0);
               else last_flag = ($urandom_range(0, 30) == 0);
               value = next_sample(value);
               send_sample(value, last_flag);
               sent++;
               phase_sent++;
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // result receiver with random and long hold-offs
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         gap = idle_enable ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready) && hold_request == 0);
      end
   end

   always @(posedge clock) begin
      resampled_point_type exp_point;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result item: sample_out=%0d run_last=%0b",
                   rsp_bus.sample_out, rsp_bus.run_last);
            error_count++;
         end else begin
            exp_point = pending_points.pop_front();
            if (rsp_bus.sample_out !== exp_point.sample) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      exp_point.sample, rsp_bus.sample_out);
               error_count++;
            end
            if (rsp_bus.run_last !== exp_point.run_last) begin
               $error("run_last mismatch: expected %0b, actual %0b",
                      exp_point.run_last, rsp_bus.run_last);
               error_count++;
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_points.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.sample_in  = '0;
      req_bus.stream_end = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = lirr_pkg::CSR_UP_FACTOR;
      csr_bus.data       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_rounding_ties();
      test_factor_extremes();
      test_phase_carry();
      test_output_stall();
      test_random_streams(RANDOM_ITEMS);

      wait_idle();
      if (pending_points.size() != 0) begin
         $error("%0d expected results never arrived", pending_points.size());
         error_count++;
      end
      $display("Sent %0d samples, checked %0d resampled points, made %0d register writes.",
               items_sent, results_seen, writes_done);
      $display("Covered default, zero, oversize and extreme factors, rounding ties, "
               , "phase carry-over and long output stalls.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lirr_pkg.sv
rtl/lirr_req_if.sv
rtl/lirr_rsp_if.sv
rtl/lirr_csr_if.sv
rtl/lirr_ctrl.sv
rtl/lirr_datapath.sv
rtl/linear_interp_rational_resampler.sv
tb/sv/linear_interp_rational_resampler_test.sv
